### rtl/sapq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sapq_pkg : shared types for the sorted adaptable priority queue
// Action and status codes, sequencer states and the control word that the
// sequencer broadcasts to every cell of the sorted chain.
// ---------------------------------------------------------------------------
package sapq_pkg;

   // port field widths
   localparam int ACTION_W      = 2;
   localparam int KEY_PORT_W    = 16;
   localparam int HANDLE_PORT_W = 4;
   localparam int COUNT_PORT_W  = 5;
   localparam int STATUS_W      = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT     = 2'd0,
      ACT_REMOVE_TOP = 2'd1,
      ACT_REMOVE_HDL = 2'd2,
      ACT_REPLACE    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_REMOVE,
      SEQ_INSERT,
      SEQ_REPORT
   } seq_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_REMOVE,
      CELL_INSERT
   } cell_op_type;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type op;
      logic        order_mode;   // 1: largest key at the front
      logic        remove_front; // remove the head cell, ignore handle match
   } cell_ctrl_type;

endpackage

### rtl/sapq_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sapq_cell : one slot of the sorted chain
// Holds one key and handle. On insert it compares the new key locally and
// either keeps, takes the new entry or takes its left neighbour's entry.
// On remove it takes its right neighbour's entry at and after the hit.
// ---------------------------------------------------------------------------
module sapq_cell #(
   parameter int KW = 16,
   parameter int HW = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sapq_pkg::cell_ctrl_type ctrl,
   input  logic [KW-1:0]          new_key,
   input  logic [HW-1:0]          new_handle,
   input  logic [KW-1:0]          left_key,
   input  logic [HW-1:0]          left_handle,
   input  logic                   left_valid,
   input  logic                   left_ins,
   input  logic [KW-1:0]          right_key,
   input  logic [HW-1:0]          right_handle,
   input  logic                   right_valid,
   input  logic                   rm_left,
   output logic [KW-1:0]          cell_key,
   output logic [HW-1:0]          cell_handle,
   output logic                   cell_valid,
   output logic                   ins_here,
   output logic                   rm_here
);
   import sapq_pkg::*;

   logic [KW-1:0] key_ff, key_in;
   logic [HW-1:0] handle_ff, handle_in;
   logic          valid_ff, valid_in;
   logic          goes_before;

   // new key stands strictly ahead of the stored one; ties go behind
   assign goes_before = ctrl.order_mode ? (new_key > key_ff) : (new_key < key_ff);
   // insertion point here or somewhere to the left; the first one wins
   assign ins_here    = left_ins || !valid_ff || goes_before;
   // removal hit here or somewhere to the left
   assign rm_here     = rm_left || (valid_ff && (handle_ff == new_handle));

   // next contents
   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      valid_in  = valid_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (left_ins) begin
               key_in    = left_key;
               handle_in = left_handle;
               valid_in  = left_valid;
            end else if (ins_here) begin
               key_in    = new_key;
               handle_in = new_handle;
               valid_in  = 1'b1;
            end
         end
         CELL_REMOVE: begin
            if (rm_here) begin
               key_in    = right_key;
               handle_in = right_handle;
               valid_in  = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign cell_key    = key_ff;
   assign cell_handle = handle_ff;
   assign cell_valid  = valid_ff;

endmodule

### rtl/sorted_adaptable_priority_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_adaptable_priority_queue : sorted list priority queue with handles
// A chain of DEPTH cells keeps the entries in queue order, front in cell 0.
// A sequencer runs each operation as a remove pass then an insert pass.
//
//  channel  | dir | transfer when          | content
//  ---------+-----+------------------------+--------------------------------
//  req_     | in  | req_tvalid & tready    | action (tuser), key, handle
//  rsp_     | out | rsp_tvalid & tready    | handle, front, count, status
//  csr_     | in  | csr_write_en           | order_mode
//
// Each operation is a remove pass and an insert pass through the cell chain,
// then the report cycle, in which the next request is taken.
// A stalled response holds the sequencer in the report cycle.
// Synchronous reset empties the chain and clears all handles; no clearing
// pass is needed.
// ---------------------------------------------------------------------------
module sorted_adaptable_priority_queue #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // config
   input  logic                          csr_write_en,
   input  logic                          csr_write_data,
   // requests
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // key[15:0], handle[19:16], zero pad
   input  logic [sapq_pkg::ACTION_W-1:0] req_tuser,  // action[1:0]
   // responses
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // assigned_handle[3:0], front_key[19:4], front_handle[23:20],
   // entry_count[28:24], is_empty[29], status[31:30]
   output logic [31:0]                   rsp_tdata
);
   import sapq_pkg::*;

   localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;

   // sequencer and item registers
   seq_state_type          state_ff, state_in;
   action_type             action_ff, action_in;
   logic [KW-1:0]          key_ff, key_in;
   logic [HANDLE_PORT_W-1:0] hdl_ff, hdl_in;
   status_type             status_ff, status_in;
   logic [HW-1:0]          assigned_ff, assigned_in;
   logic [DEPTH-1:0]       busy_ff, busy_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   order_mode_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_data_ff, rsp_data_in;

   // cell chain signals
   cell_ctrl_type          ctrl;
   logic [KW-1:0]          new_key;
   logic [HW-1:0]          new_handle;
   logic [KW-1:0]          c_key    [DEPTH];
   logic [HW-1:0]          c_handle [DEPTH];
   logic                   c_valid  [DEPTH];
   logic                   c_ins    [DEPTH];
   logic                   c_rm     [DEPTH];

   logic [HW-1:0]          free_hdl;
   logic [HW-1:0]          hdl_idx;
   logic                   hdl_range_ok;
   logic                   take;
   logic [HANDLE_PORT_W-1:0] out_assigned;
   logic [KEY_PORT_W-1:0]  out_front_key;
   logic [HANDLE_PORT_W-1:0] out_front_hdl;

   // lowest free handle
   always_comb begin
      free_hdl = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_hdl = HW'(i);
         end
      end
   end

   assign hdl_range_ok = (int'(hdl_ff) < DEPTH);
   assign hdl_idx      = HW'(hdl_ff);

   // cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KW-1:0] l_key, r_key;
      logic [HW-1:0] l_hdl, r_hdl;
      logic          l_valid, r_valid, l_ins, l_rm;

      if (g == 0) begin : g_head
         assign l_key   = '0;
         assign l_hdl   = '0;
         assign l_valid = 1'b0;
         assign l_ins   = 1'b0;
         assign l_rm    = ctrl.remove_front;
      end else begin : g_body
         assign l_key   = c_key[g-1];
         assign l_hdl   = c_handle[g-1];
         assign l_valid = c_valid[g-1];
         assign l_ins   = c_ins[g-1];
         assign l_rm    = c_rm[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign r_key   = '0;
         assign r_hdl   = '0;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_key   = c_key[g+1];
         assign r_hdl   = c_handle[g+1];
         assign r_valid = c_valid[g+1];
      end

      sapq_cell #(
         .KW (KW),
         .HW (HW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_key      (new_key),
         .new_handle   (new_handle),
         .left_key     (l_key),
         .left_handle  (l_hdl),
         .left_valid   (l_valid),
         .left_ins     (l_ins),
         .right_key    (r_key),
         .right_handle (r_hdl),
         .right_valid  (r_valid),
         .rm_left      (l_rm),
         .cell_key     (c_key[g]),
         .cell_handle  (c_handle[g]),
         .cell_valid   (c_valid[g]),
         .ins_here     (c_ins[g]),
         .rm_here      (c_rm[g])
      );
   end

   // report fields, taken from the chain after both passes
   assign out_assigned  = (status_ff == ST_OK &&
                           (action_ff == ACT_INSERT || action_ff == ACT_REPLACE))
                          ? HANDLE_PORT_W'(assigned_ff) : '0;
   assign out_front_key = c_valid[0] ? KEY_PORT_W'(c_key[0]) : '0;
   assign out_front_hdl = c_valid[0] ? HANDLE_PORT_W'(c_handle[0]) : '0;

   // sequencer: next state, chain control, bookkeeping
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      hdl_in       = hdl_ff;
      status_in    = status_ff;
      assigned_in  = assigned_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      take         = 1'b0;
      ctrl.op           = CELL_HOLD;
      ctrl.order_mode   = order_mode_ff;
      ctrl.remove_front = 1'b0;
      new_key      = key_ff;
      new_handle   = hdl_idx;

      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            take       = req_tvalid;
         end

         SEQ_REMOVE: begin
            state_in = SEQ_INSERT;
            status_in = ST_OK;
            case (action_ff)
               ACT_INSERT: begin
                  if (int'(count_ff) >= DEPTH) begin
                     status_in = ST_FULL;
                  end else begin
                     assigned_in       = free_hdl;
                     busy_in[free_hdl] = 1'b1;
                  end
               end
               ACT_REMOVE_TOP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     ctrl.op               = CELL_REMOVE;
                     ctrl.remove_front     = 1'b1;
                     busy_in[c_handle[0]]  = 1'b0;
                     count_in              = count_ff - 1'b1;
                  end
               end
               default: begin
                  if (!hdl_range_ok || !busy_ff[hdl_idx]) begin
                     status_in = ST_UNKNOWN;
                  end else begin
                     ctrl.op     = CELL_REMOVE;
                     count_in    = count_ff - 1'b1;
                     assigned_in = hdl_idx;
                     if (action_ff == ACT_REMOVE_HDL) begin
                        busy_in[hdl_idx] = 1'b0;
                     end
                  end
               end
            endcase
         end

         SEQ_INSERT: begin
            state_in   = SEQ_REPORT;
            new_handle = assigned_ff;
            if (status_ff == ST_OK &&
                (action_ff == ACT_INSERT || action_ff == ACT_REPLACE)) begin
               ctrl.op  = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end

         SEQ_REPORT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {status_ff, (count_ff == '0), COUNT_PORT_W'(count_ff),
                               out_front_hdl, out_front_key, out_assigned};
               req_tready   = 1'b1;
               take         = req_tvalid;
               if (!req_tvalid) begin
                  state_in = SEQ_IDLE;
               end
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      // capture a new request
      if (take) begin
         state_in  = SEQ_REMOVE;
         action_in = action_type'(req_tuser);
         key_in    = KW'(req_tdata[KEY_PORT_W-1:0]);
         hdl_in    = req_tdata[KEY_PORT_W +: HANDLE_PORT_W];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         busy_ff       <= '0;
         count_ff      <= '0;
         order_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            order_mode_ff <= csr_write_data;
         end
      end
   end

   // item and response payload
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      key_ff      <= key_in;
      hdl_ff      <= hdl_in;
      status_ff   <= status_in;
      assigned_ff <= assigned_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
